// ===== design/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg
// Types and constants shared by the price spike filter modules.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int COUNT_BITS = 40;
  localparam int CFG_W      = 31;
  localparam int TS_W       = 64;
  localparam int PRICE_W    = 32;
  localparam int DAY_W      = 32;

  // day key = (timestamp >> 9) / 5^9, by multiplying with a rounded-up reciprocal
  // of 5^9 scaled by 2^76, exact for every 55-bit dividend
  localparam int DAY_SHIFT    = 9;
  localparam logic [20:0] DAY_ODD = 21'd1953125;
  localparam int RECIP_W      = 56;
  localparam logic [RECIP_W-1:0] DAY_RECIP =
    RECIP_W'(((77'd1 << 76) / 77'(DAY_ODD)) + 77'd1);
  localparam int FRONT_STAGES = 3;

  // queue between front and back
  localparam int MQ_DEPTH = 4;
  localparam int MQ_PTR_W = 2;
  localparam int MQ_CNT_W = 3;

  // result queue
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = 1;
  localparam int OQ_CNT_W = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    REASON_KEPT  = 2'd0,
    REASON_NULL  = 2'd1,
    REASON_LEVEL = 2'd2,
    REASON_JUMP  = 2'd3
  } reason_t;

  typedef enum logic {
    CFG_JUMP_THRESHOLD = 1'b0,
    CFG_LEVEL_LIMIT    = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [TS_W-1:0]           timestamp;
    logic signed [PRICE_W-1:0] mid_price;
    logic                      is_null;
  } psf_in_t;

  typedef struct packed {
    logic                  keep;
    reason_t               drop_reason;
    logic [COUNT_BITS-1:0] kept_count;
    logic [COUNT_BITS-1:0] jump_drop_count;
    logic [COUNT_BITS-1:0] level_drop_count;
  } psf_out_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic [DAY_W-1:0]          day;
    logic signed [PRICE_W-1:0] mid;
    logic                      is_null;
    logic                      over;
  } psf_tick_t;

endpackage

// ===== design/price_spike_filter.sv =====
// ----------------------------------------------------------------------------
// price_spike_filter
// Per-tick mid price spike and level filter with saturating counters.
// ----------------------------------------------------------------------------
// Ticks enter on a queue-style port: a transfer happens when push is high and
// full is low. Results leave the same way: the oldest result sits on result
// while empty is low and transfers when pop is high. Every tick gives exactly
// one result, in order. jump_threshold (index 0) and level_limit (index 1)
// are written over the cfg port, which is always ready; write them only
// while no tick is in flight.
// From input transfer to result, a tick passes the first front stage (partial
// products of timestamp >> 9 with a reciprocal of 5^9), which loads at the
// transfer edge, then the product sum, the day key stage and the tick queue,
// from which the baseline compare writes the result queue. Throughput is one
// tick per cycle while pop keeps up, set by the baseline compare-and-update
// loop in the back end. When pop stalls, the two-entry result queue and then
// the four-entry tick queue fill, after which the front pipeline holds and
// full rises. Synchronous reset restores register defaults, clears the
// baseline and the counters, and empties all queues.
// ----------------------------------------------------------------------------
module price_spike_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  psf_pkg::psf_in_t            item,
  input  logic                        pop,
  output logic                        empty,
  output psf_pkg::psf_out_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [psf_pkg::PRICE_W-1:0] cfg_data
);
  import psf_pkg::*;

  logic [CFG_W-1:0] jump_threshold;
  logic [CFG_W-1:0] level_limit;
  logic             tick_push;
  logic             tick_full;
  logic             tick_pop;
  logic             tick_empty;
  psf_tick_t        tick_in;
  psf_tick_t        tick_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= CFG_W'(1000000);
      level_limit    <= CFG_W'(10000000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_JUMP_THRESHOLD: jump_threshold <= cfg_data[CFG_W-1:0];
        CFG_LEVEL_LIMIT:    level_limit    <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  psf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .level_limit (level_limit),
    .tick_push   (tick_push),
    .tick        (tick_in),
    .tick_full   (tick_full)
  );

  psf_mid_queue u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (tick_push),
    .wdata (tick_in),
    .full  (tick_full),
    .pop   (tick_pop),
    .rdata (tick_out),
    .empty (tick_empty)
  );

  psf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .jump_threshold (jump_threshold),
    .tick           (tick_out),
    .tick_empty     (tick_empty),
    .tick_pop       (tick_pop),
    .pop            (pop),
    .empty          (empty),
    .result         (result)
  );

endmodule

// ===== design/psf_front.sv =====
// ----------------------------------------------------------------------------
// psf_front
// Day key pipeline: timestamp >> 9 times a reciprocal of 5^9 as four partial
// products, their sum, then the day key and level compare, handed on as a
// classified tick.
// ----------------------------------------------------------------------------
module psf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  psf_pkg::psf_in_t           item,
  input  logic [psf_pkg::CFG_W-1:0]  level_limit,
  output logic                       tick_push,
  output psf_pkg::psf_tick_t         tick,
  input  logic                       tick_full
);
  import psf_pkg::*;

  logic [54:0]               dividend;
  logic [22:0]               div_hi;
  logic [31:0]               div_lo;
  logic [63:0]               prod_ll;
  logic [55:0]               prod_lh;
  logic [54:0]               prod_hl;
  logic [46:0]               prod_hh;
  logic [57:0]               cross_sum;
  logic [46:0]               high_prod;
  logic [47:0]               quot_sum;
  logic [DAY_W-1:0]          day_key;
  logic signed [PRICE_W-1:0] mid_pipe [FRONT_STAGES];
  logic [FRONT_STAGES-1:0]   null_pipe;
  logic [FRONT_STAGES-1:0]   pipe_valid;
  logic                      adv;

  assign dividend = item.timestamp[TS_W-1:DAY_SHIFT];
  assign div_hi   = dividend[54:32];
  assign div_lo   = dividend[31:0];

  // quotient is the product shifted right by 76, i.e. bits 12 and up of this sum
  assign quot_sum = {1'b0, high_prod} + {22'b0, cross_sum[57:32]};

  assign adv  = !(pipe_valid[FRONT_STAGES-1] && tick_full);
  assign full = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (adv) begin
      pipe_valid <= {pipe_valid[FRONT_STAGES-2:0], push};
    end
    if (adv) begin
      prod_ll      <= {32'b0, div_lo} * {32'b0, DAY_RECIP[31:0]};
      prod_lh      <= {24'b0, div_lo} * {32'b0, DAY_RECIP[55:32]};
      prod_hl      <= {32'b0, div_hi} * {23'b0, DAY_RECIP[31:0]};
      prod_hh      <= {24'b0, div_hi} * {23'b0, DAY_RECIP[55:32]};
      cross_sum    <= {2'b0, prod_lh} + {3'b0, prod_hl} + {26'b0, prod_ll[63:32]};
      high_prod    <= prod_hh;
      day_key      <= quot_sum[43:12];
      mid_pipe[0]  <= item.mid_price;
      null_pipe[0] <= item.is_null;
      for (int i = 1; i < FRONT_STAGES; i++) begin
        mid_pipe[i]  <= mid_pipe[i-1];
        null_pipe[i] <= null_pipe[i-1];
      end
    end
  end

  assign tick_push    = pipe_valid[FRONT_STAGES-1] && !tick_full;
  assign tick.day     = day_key;
  assign tick.mid     = mid_pipe[FRONT_STAGES-1];
  assign tick.is_null = null_pipe[FRONT_STAGES-1];
  assign tick.over    = mid_pipe[FRONT_STAGES-1] > $signed({1'b0, level_limit});

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    pipe_valid[FRONT_STAGES-1] && !adv |=> pipe_valid[FRONT_STAGES-1])
    else $error("finished tick lost while the queue was full");

endmodule

// ===== design/psf_mid_queue.sv =====
// ----------------------------------------------------------------------------
// psf_mid_queue
// Short queue of classified ticks between the front and the back.
// ----------------------------------------------------------------------------
module psf_mid_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  psf_pkg::psf_tick_t  wdata,
  output logic                full,
  input  logic                pop,
  output psf_pkg::psf_tick_t  rdata,
  output logic                empty
);
  import psf_pkg::*;

  psf_tick_t           mem [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wr_ptr;
  logic [MQ_PTR_W-1:0] rd_ptr;
  logic [MQ_CNT_W-1:0] count;

  assign full  = (count == MQ_CNT_W'(MQ_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MQ_CNT_W'(MQ_DEPTH))
    else $error("tick queue count out of range");

endmodule

// ===== design/psf_back.sv =====
// ----------------------------------------------------------------------------
// psf_back
// Baseline compare and update, saturating counters, and the result queue.
// ----------------------------------------------------------------------------
module psf_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [psf_pkg::CFG_W-1:0]  jump_threshold,
  input  psf_pkg::psf_tick_t         tick,
  input  logic                       tick_empty,
  output logic                       tick_pop,
  input  logic                       pop,
  output logic                       empty,
  output psf_pkg::psf_out_t          result
);
  import psf_pkg::*;

  logic [DAY_W-1:0]          base_day;
  logic signed [PRICE_W-1:0] base_mid;
  logic                      base_valid;
  logic [COUNT_BITS-1:0]     kept_total;
  logic [COUNT_BITS-1:0]     jump_total;
  logic [COUNT_BITS-1:0]     level_total;

  logic [COUNT_BITS-1:0] kept_total_next;
  logic [COUNT_BITS-1:0] jump_total_next;
  logic [COUNT_BITS-1:0] level_total_next;

  psf_out_t            oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr;
  logic [OQ_PTR_W-1:0] oq_rd;
  logic [OQ_CNT_W-1:0] oq_count;
  logic                oq_full;
  logic                fire;
  logic                same_day;
  logic signed [PRICE_W:0] diff;
  logic [PRICE_W:0]    abs_diff;
  logic                jump;
  reason_t             reason;
  psf_out_t            res;

  assign oq_full  = (oq_count == OQ_CNT_W'(OQ_DEPTH));
  assign empty    = (oq_count == '0);
  assign result   = oq[oq_rd];
  assign fire     = !tick_empty && !oq_full;
  assign tick_pop = fire;

  assign same_day = base_valid && (tick.day == base_day);
  assign diff     = {tick.mid[PRICE_W-1], tick.mid} - {base_mid[PRICE_W-1], base_mid};
  assign abs_diff = diff[PRICE_W] ? (PRICE_W+1)'(-diff) : diff;
  assign jump     = abs_diff >= {2'b00, jump_threshold};

  always_comb begin
    if (tick.is_null) begin
      reason = REASON_NULL;
    end else if (same_day && jump) begin
      reason = REASON_JUMP;
    end else if (tick.over) begin
      reason = REASON_LEVEL;
    end else begin
      reason = REASON_KEPT;
    end
  end

  always_comb begin
    kept_total_next  = kept_total;
    jump_total_next  = jump_total;
    level_total_next = level_total;
    case (reason)
      REASON_KEPT: begin
        if (kept_total != COUNT_MAX) kept_total_next = kept_total + 1'b1;
      end
      REASON_JUMP: begin
        if (jump_total != COUNT_MAX) jump_total_next = jump_total + 1'b1;
      end
      REASON_LEVEL: begin
        if (level_total != COUNT_MAX) level_total_next = level_total + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.keep             = (reason == REASON_KEPT);
    res.drop_reason      = reason;
    res.kept_count       = kept_total_next;
    res.jump_drop_count  = jump_total_next;
    res.level_drop_count = level_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_day    <= '0;
      base_mid    <= '0;
      base_valid  <= 1'b0;
      kept_total  <= '0;
      jump_total  <= '0;
      level_total <= '0;
      oq_wr       <= '0;
      oq_rd       <= '0;
      oq_count    <= '0;
    end else begin
      if (fire) begin
        kept_total  <= kept_total_next;
        jump_total  <= jump_total_next;
        level_total <= level_total_next;
        if (reason == REASON_KEPT) begin
          base_day   <= tick.day;
          base_mid   <= tick.mid;
          base_valid <= 1'b1;
        end else if (reason == REASON_LEVEL && !same_day) begin
          base_valid <= 1'b0;
        end
        oq_wr <= oq_wr + 1'b1;
      end
      if (pop && !empty) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (fire && !(pop && !empty)) begin
        oq_count <= oq_count + 1'b1;
      end else if (!fire && pop && !empty) begin
        oq_count <= oq_count - 1'b1;
      end
    end
    if (fire) begin
      oq[oq_wr] <= res;
    end
  end

  a_kept_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> kept_total >= $past(kept_total))
    else $error("kept counter went backwards");

  a_level_clears_base: assert property (@(posedge clk) disable iff (rst)
    fire && !tick.is_null && !same_day && tick.over |=> !base_valid)
    else $error("level drop off the baseline day kept a baseline");

  a_dropped_holds_base: assert property (@(posedge clk) disable iff (rst)
    fire && same_day && reason != REASON_KEPT |=> $stable(base_mid) && $stable(base_day))
    else $error("dropped tick moved the baseline");

endmodule

// ===== bench/price_spike_filter_tb.sv =====
// ----------------------------------------------------------------------------
// price_spike_filter_tb
// Self-checking bench for the tick spike and level filter. A short table of
// directed ticks covers the field extremes, the day boundary, the jump and
// level drops and the baseline clear. Randomized phases follow, each under
// its own register setting, most ticks on the baseline day near the thresholds.
// Each result is compared field by field with its table verdict or the bench's
// own filter model; both queue sides idle in random bursts but in the last phase.
// ----------------------------------------------------------------------------
module price_spike_filter_tb;
  import psf_pkg::*;

  localparam int   PHASES      = 8;
  localparam int   PHASE_TICKS = 230;
  localparam int   DRAIN_WAIT  = 40;
  localparam int   STALL_LIMIT = 2000;
  localparam logic [63:0] NS_PER_DAY = 64'd1000000000;
  localparam logic [63:0] TS_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    psf_in_t  tick;
    bit       typed;
    psf_out_t verdict;
  } tick_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  psf_in_t  item = '0;
  logic     pop = 1'b0;
  logic     empty;
  psf_out_t result;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_index = CFG_JUMP_THRESHOLD;
  logic [PRICE_W-1:0] cfg_data = '0;

  // filter model state
  logic [CFG_W-1:0]      jump_lim  = 31'd1000000;
  logic [CFG_W-1:0]      level_lim = 31'd10000000;
  logic [DAY_W-1:0]      anchor_day = '0;
  longint                anchor_mid = 0;
  bit                    anchor_ok  = 1'b0;
  logic [COUNT_BITS-1:0] kept_n  = '0;
  logic [COUNT_BITS-1:0] jump_n  = '0;
  logic [COUNT_BITS-1:0] level_n = '0;

  psf_out_t  pending_verdicts[$];
  bit        row_typed;
  psf_out_t  row_verdict;
  tick_row_t dir_rows [19];
  logic [31:0] jump_cfg [PHASES];
  logic [31:0] level_cfg [PHASES];
  int        mismatches = 0;
  int        stall_cycles = 0;
  int        gap_left = 0;
  bit        calm = 1'b0;

  price_spike_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // advances the filter model by one tick and returns its verdict
  function automatic psf_out_t filter_tick(psf_in_t t);
    psf_out_t         v;
    logic [DAY_W-1:0] tick_day;
    longint           mid;
    longint           diff;
    bit               over;
    v = '0;
    v.drop_reason = REASON_KEPT;
    if (t.is_null) begin
      v.drop_reason = REASON_NULL;
    end else begin
      tick_day = 32'(t.timestamp / NS_PER_DAY);
      mid      = longint'($signed(t.mid_price));
      over     = mid > longint'({33'b0, level_lim});
      diff     = mid - anchor_mid;
      if (diff < 0) diff = -diff;
      if (!anchor_ok || tick_day != anchor_day) begin
        if (over) begin
          v.drop_reason = REASON_LEVEL;
          level_n = sat_inc(level_n);
          anchor_ok = 1'b0;
        end else begin
          v.keep = 1'b1;
          kept_n = sat_inc(kept_n);
          anchor_day = tick_day;
          anchor_mid = mid;
          anchor_ok = 1'b1;
        end
      end else if (diff >= longint'({33'b0, jump_lim})) begin
        v.drop_reason = REASON_JUMP;
        jump_n = sat_inc(jump_n);
      end else if (over) begin
        v.drop_reason = REASON_LEVEL;
        level_n = sat_inc(level_n);
      end else begin
        v.keep = 1'b1;
        kept_n = sat_inc(kept_n);
        anchor_mid = mid;
      end
    end
    v.kept_count       = kept_n;
    v.jump_drop_count  = jump_n;
    v.level_drop_count = level_n;
    return v;
  endfunction

  function automatic tick_row_t row(logic [63:0] ts, logic [31:0] mid, bit nul, bit typed,
                                    bit keep, reason_t why, int kc, int jc, int lc);
    tick_row_t r;
    r.tick    = '{timestamp: ts, mid_price: mid, is_null: nul};
    r.typed   = typed;
    r.verdict = '{keep: keep, drop_reason: why, kept_count: COUNT_BITS'(kc),
                  jump_drop_count: COUNT_BITS'(jc), level_drop_count: COUNT_BITS'(lc)};
    return r;
  endfunction

  // mostly on the baseline day, sometimes the next days, an aliased day key or noise
  function automatic logic [63:0] pick_stamp();
    longint unsigned d;
    int              sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return {$urandom(), $urandom()};
    d = {32'b0, anchor_day};
    if (sel <= 3 || !anchor_ok) d = d + $urandom_range(1, 3);
    else if (sel == 4) d = d + 64'h1_0000_0000;
    return d * NS_PER_DAY + $urandom_range(0, 999999999);
  endfunction

  // prices around the baseline, right at the jump threshold, at the level limit or noise
  function automatic logic [31:0] pick_mid();
    longint          base;
    longint          jl;
    longint          m;
    longint unsigned span;
    jl   = longint'({33'b0, jump_lim});
    base = anchor_ok ? anchor_mid : longint'($urandom_range(0, {1'b0, level_lim}));
    case ($urandom_range(0, 9))
      0, 1, 2: m = base + longint'($urandom_range(0, 200)) - 100;
      3:       m = base + jl;
      4:       m = base - jl;
      5:       m = base + jl - 1;
      6:       m = base - jl + 1;
      7: begin
        span = longint'(4 * jl + 1);
        m = base - 2 * jl + longint'({$urandom(), $urandom()} % span);
      end
      8:       m = longint'({33'b0, level_lim}) + longint'($urandom_range(0, 2)) - 1;
      default: m = longint'($signed($urandom()));
    endcase
    return m[31:0];
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // transfer monitor, filter model update and stall watchdog
  always @(posedge clk) begin
    psf_out_t v;
    psf_out_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_JUMP_THRESHOLD) jump_lim = cfg_data[CFG_W-1:0];
        else level_lim = cfg_data[CFG_W-1:0];
      end
      if (push && !full) begin
        v = filter_tick(item);
        if (row_typed) v = row_verdict;
        pending_verdicts.insert(pending_verdicts.size(), v);
      end
      if (pop && !empty) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, got %0h", $time, result);
        end else begin
          want = pending_verdicts.pop_front();
          check_field("keep", 64'(want.keep), 64'(result.keep));
          check_field("drop_reason", 64'(want.drop_reason), 64'(result.drop_reason));
          check_field("kept_count", 64'(want.kept_count), 64'(result.kept_count));
          check_field("jump_drop_count", 64'(want.jump_drop_count),
                      64'(result.jump_drop_count));
          check_field("level_drop_count", 64'(want.level_drop_count),
                      64'(result.level_drop_count));
        end
      end
    end
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no transfer for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_verdicts.size());
      $display("FAIL");
      $finish;
    end
  end

  // result side: pop runs of random length, broken by short stalls unless calm
  initial begin
    int n;
    forever begin
      n = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      repeat (n) begin
        @(negedge clk);
        pop <= 1'b1;
      end
      if (!calm) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          @(negedge clk);
          pop <= 1'b0;
        end
      end
    end
  end

  task automatic send_tick(bit from_table, tick_row_t r);
    int n;
    if (!calm) begin
      if (gap_left == 0) begin
        n = $urandom_range(1, 4);
        @(negedge clk);
        push <= 1'b0;
        repeat (n - 1) @(negedge clk);
        gap_left = ($urandom_range(0, 5) == 0) ? 50 : $urandom_range(1, 10);
      end
      gap_left--;
    end
    @(negedge clk);
    if (!from_table) begin
      r.tick.timestamp = pick_stamp();
      r.tick.mid_price = pick_mid();
      r.tick.is_null   = ($urandom_range(0, 15) == 0);
      r.typed = 1'b0;
    end
    row_typed   = r.typed;
    row_verdict = r.verdict;
    push <= 1'b1;
    item <= r.tick;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  initial begin
    tick_row_t blank;
    blank = row('0, '0, 1'b0, 1'b0, 1'b0, REASON_KEPT, 0, 0, 0);

    // reset thresholds: jump 1000000, level 10000000
    dir_rows[0]  = row(64'd0, 32'd0, 1, 1, 0, REASON_NULL, 0, 0, 0);
    dir_rows[1]  = row(TS_MAX, 32'h7FFF_FFFF, 0, 1, 0, REASON_LEVEL, 0, 0, 1);
    dir_rows[2]  = row(64'd0, 32'h8000_0000, 0, 1, 1, REASON_KEPT, 1, 0, 1);
    dir_rows[3]  = row(64'd5, -32'sd2146483649, 0, 1, 1, REASON_KEPT, 2, 0, 1);
    // last instant of day 0, change exactly at the threshold
    dir_rows[4]  = row(64'd999999999, -32'sd2145483649, 0, 1, 0, REASON_JUMP, 2, 1, 1);
    dir_rows[5]  = row(64'd7, 32'd10000000, 0, 1, 0, REASON_JUMP, 2, 2, 1);
    dir_rows[6]  = row(64'd1000000000, 32'd10000000, 0, 1, 1, REASON_KEPT, 3, 2, 1);
    dir_rows[7]  = row(64'd1000000005, 32'd10000001, 0, 1, 0, REASON_LEVEL, 3, 2, 2);
    dir_rows[8]  = row(64'd1000000006, 32'd9000001, 0, 1, 1, REASON_KEPT, 4, 2, 2);
    dir_rows[9]  = row(64'd1000000007, 32'd0, 1, 1, 0, REASON_NULL, 4, 2, 2);
    // both tests fail, jump wins
    dir_rows[10] = row(64'd1999999999, 32'd10000001, 0, 1, 0, REASON_JUMP, 4, 3, 2);
    // quotient 2^32 + 1 truncates to the baseline day
    dir_rows[11] = row(64'd4294967297000000000, 32'd9000002, 0, 1, 1, REASON_KEPT, 5, 3, 2);
    dir_rows[12] = row(TS_MAX, 32'hFFFF_FFFF, 0, 1, 1, REASON_KEPT, 6, 3, 2);
    dir_rows[13] = row(TS_MAX, 32'h7FFF_FFFF, 1, 1, 0, REASON_NULL, 6, 3, 2);
    dir_rows[14] = row(TS_MAX - 1, 32'h7FFF_FFFF, 0, 1, 0, REASON_JUMP, 6, 4, 2);
    dir_rows[15] = row(TS_MAX - 2, 32'd0, 0, 1, 1, REASON_KEPT, 7, 4, 2);
    // level drop on a new day clears the baseline
    dir_rows[16] = row(64'd3000000000, 32'd10000001, 0, 1, 0, REASON_LEVEL, 7, 4, 3);
    dir_rows[17] = row(TS_MAX - 3, 32'd2000000, 0, 0, 0, REASON_KEPT, 0, 0, 0);
    dir_rows[18] = row(TS_MAX - 3, 32'd3000001, 0, 0, 0, REASON_KEPT, 0, 0, 0);

    jump_cfg[0] = 32'd0;         level_cfg[0] = 32'hFFFF_FFFF;
    jump_cfg[1] = 32'h7FFF_FFFF; level_cfg[1] = 32'd0;
    jump_cfg[2] = 32'hFFFF_FFFF; level_cfg[2] = 32'h8000_0000;
    for (int p = 3; p < PHASES; p++) begin
      jump_cfg[p]  = $urandom_range(1, 3000000) | {1'($urandom_range(0, 1)), 31'b0};
      level_cfg[p] = $urandom_range(1000000, 30000000) | {1'($urandom_range(0, 1)), 31'b0};
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_tick(1'b1, dir_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_JUMP_THRESHOLD, jump_cfg[p]);
      write_reg(CFG_LEVEL_LIMIT, level_cfg[p]);
      @(negedge clk);
      cfg_valid <= 1'b0;
      calm = (p == PHASES - 1);
      repeat (PHASE_TICKS) send_tick(1'b0, blank);
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
